FILE: sv/pne_pkg.sv
`timescale 1ns / 1ps
package pne_pkg;

  localparam int NUM_LIGHTS_DEF = 4;
  localparam int PIXEL_BITS_DEF = 8;
  localparam int MAX_LIGHTS     = 4;

  localparam int COEF_W    = 16;
  localparam int DATA_W    = 64;
  localparam int ADDR_W    = 5;
  localparam int NORM_BIT  = 25;
  localparam int NORM_W    = NORM_BIT + 1;
  localparam int SQ_W      = 2 * NORM_W;
  localparam int Q_W       = SQ_W + 2;
  localparam int ALB_SHIFT = 12;
  localparam int ASUM_W    = Q_W - ALB_SHIFT;
  localparam int ROOT_W    = (Q_W + 1) / 2;
  localparam int UNIT_FRAC = 14;
  localparam int UNIT_W    = 16;
  localparam int QUO_W     = UNIT_FRAC + 1;
  localparam int NUM_W     = NORM_W + UNIT_FRAC + 1;
  localparam int ALB_W     = 20;

  localparam logic [ALB_W-1:0] ALBEDO_MAX = {ALB_W{1'b1}};
  localparam logic [QUO_W-1:0] UNIT_ONE   = QUO_W'(1) << UNIT_FRAC;

  localparam logic [1:0] REG_ROW_X = 2'd0;
  localparam logic [1:0] REG_ROW_Y = 2'd1;
  localparam logic [1:0] REG_ROW_Z = 2'd2;

  typedef struct packed {
    logic                       valid;
    logic                       zero;
    logic                       sat;
    logic [2:0]                 neg;
    logic [2:0][NORM_W-1:0]     nmag;
  } sq_side_t;

  typedef struct packed {
    logic                       valid;
    logic                       zero;
    logic                       sat;
    logic [2:0]                 neg;
    logic [ROOT_W-1:0]          alb;
  } div_side_t;

endpackage

FILE: sv/photometric_normal_estimator.sv
`timescale 1ns / 1ps
// Throughput: one pixel per cycle while the spare output entry is empty; the
// 27-stage square-root and 15-stage divider pipelines advance one bit per stage.
// A two-entry output skid keeps input accepted while one result waits.
// Reset (rst, synchronous) clears valids and the three coefficient rows.
module photometric_normal_estimator #(
  parameter int NUM_LIGHTS = pne_pkg::NUM_LIGHTS_DEF,
  parameter int PIXEL_BITS = pne_pkg::PIXEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pne_pkg::ADDR_W-1:0]    paddr,
  input  logic [pne_pkg::DATA_W-1:0]    pwdata,
  output logic [pne_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [PIXEL_BITS-1:0]         intensity_0,
  input  logic [PIXEL_BITS-1:0]         intensity_1,
  input  logic [PIXEL_BITS-1:0]         intensity_2,
  input  logic [PIXEL_BITS-1:0]         intensity_3,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [pne_pkg::UNIT_W-1:0] unit_nx,
  output logic signed [pne_pkg::UNIT_W-1:0] unit_ny,
  output logic signed [pne_pkg::UNIT_W-1:0] unit_nz,
  output logic [pne_pkg::ALB_W-1:0]     albedo,
  output logic                          degenerate
);

  import pne_pkg::*;

  localparam int PW = COEF_W + PIXEL_BITS + 1;
  localparam int MW = PW + 2;
  localparam int LW = $clog2(MW);

  // config registers
  logic [DATA_W-1:0] row_x, row_y, row_z;
  logic [1:0]        reg_idx;

  assign reg_idx = paddr[ADDR_W-1:3];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_x <= '0;
      row_y <= '0;
      row_z <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_ROW_X: row_x <= pwdata;
        REG_ROW_Y: row_y <= pwdata;
        REG_ROW_Z: row_z <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROW_X: prdata = row_x;
      REG_ROW_Y: prdata = row_y;
      REG_ROW_Z: prdata = row_z;
      default:   prdata = '0;
    endcase
  end

  // pipeline control
  logic adv;
  logic spare_v;
  logic v1, v2, v3, v4, v5, v6, v7;

  assign adv      = !spare_v;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5; v7 <= v6;
    end
  end

  // stage 1: products
  logic [MAX_LIGHTS-1:0][PIXEL_BITS-1:0] pix;
  logic [DATA_W-1:0]                     rows [3];
  logic signed [PW-1:0]                  prod [3][NUM_LIGHTS];

  assign pix  = {intensity_3, intensity_2, intensity_1, intensity_0};
  assign rows[0] = row_x;
  assign rows[1] = row_y;
  assign rows[2] = row_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < NUM_LIGHTS; k++) begin
          prod[i][k] <= PW'($signed(rows[i][COEF_W*k +: COEF_W]) *
                            $signed({1'b0, pix[k]}));
        end
      end
    end
  end

  // stage 2: sums and magnitudes
  logic signed [MW-1:0] s_sum [3];
  logic [MW-1:0]        mag2 [3];
  logic [2:0]           neg2;
  logic                 zero2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_sum[i] = '0;
      for (int k = 0; k < NUM_LIGHTS; k++) begin
        s_sum[i] = s_sum[i] + MW'(prod[i][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        neg2[i] <= s_sum[i][MW-1];
        mag2[i] <= s_sum[i][MW-1] ? $unsigned(-s_sum[i]) : $unsigned(s_sum[i]);
      end
      zero2 <= (s_sum[0] == '0) && (s_sum[1] == '0) && (s_sum[2] == '0);
    end
  end

  // stage 3: max, saturation, squares for albedo
  logic [MW-1:0]     mx_c;
  logic [MW-1:0]     mx3;
  logic [MW-1:0]     mag3 [3];
  logic [SQ_W-1:0]   asq3 [3];
  logic [2:0]        neg3;
  logic              zero3, sat3;

  always_comb begin
    mx_c = mag2[0];
    if (mag2[1] > mx_c) mx_c = mag2[1];
    if (mag2[2] > mx_c) mx_c = mag2[2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mx3   <= mx_c;
      sat3  <= |mx_c[MW-1:NORM_W];
      neg3  <= neg2;
      zero3 <= zero2;
      for (int i = 0; i < 3; i++) begin
        mag3[i] <= mag2[i];
        asq3[i] <= mag2[i][NORM_W-1:0] * mag2[i][NORM_W-1:0];
      end
    end
  end

  // stage 4: albedo sum, leading one
  logic [LW-1:0]     lead_c, lead4;
  logic [Q_W-1:0]    asum_c;
  logic [ASUM_W-1:0] asum4;
  logic [MW-1:0]     mag4 [3];
  logic [2:0]        neg4;
  logic              zero4, sat4;

  always_comb begin
    lead_c = '0;
    for (int b = 0; b < MW; b++) begin
      if (mx3[b]) lead_c = LW'(b);
    end
    asum_c = Q_W'(asq3[0]) + Q_W'(asq3[1]) + Q_W'(asq3[2]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lead4 <= lead_c;
      asum4 <= asum_c[Q_W-1:ALB_SHIFT];
      neg4  <= neg3;
      zero4 <= zero3;
      sat4  <= sat3;
      for (int i = 0; i < 3; i++) mag4[i] <= mag3[i];
    end
  end

  // stage 5: normalize
  logic [MW-1:0]     shf [3];
  logic [NORM_W-1:0] nmag5 [3];
  logic [ASUM_W-1:0] asum5;
  logic [2:0]        neg5;
  logic              zero5, sat5;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (lead4 >= LW'(NORM_BIT)) shf[i] = mag4[i] >> (lead4 - LW'(NORM_BIT));
      else                        shf[i] = mag4[i] << (LW'(NORM_BIT) - lead4);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) nmag5[i] <= shf[i][NORM_W-1:0];
      asum5 <= asum4;
      neg5  <= neg4;
      zero5 <= zero4;
      sat5  <= sat4;
    end
  end

  // stage 6: squares of normalized magnitudes
  logic [SQ_W-1:0]   nsq6 [3];
  logic [NORM_W-1:0] nmag6 [3];
  logic [ASUM_W-1:0] asum6;
  logic [2:0]        neg6;
  logic              zero6, sat6;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        nsq6[i]  <= nmag5[i] * nmag5[i];
        nmag6[i] <= nmag5[i];
      end
      asum6 <= asum5;
      neg6  <= neg5;
      zero6 <= zero5;
      sat6  <= sat5;
    end
  end

  // stage 7: sum of squares
  logic [Q_W-1:0]    q7;
  logic [NORM_W-1:0] nmag7 [3];
  logic [ASUM_W-1:0] asum7;
  logic [2:0]        neg7;
  logic              zero7, sat7;

  always_ff @(posedge clk) begin
    if (adv) begin
      q7    <= Q_W'(nsq6[0]) + Q_W'(nsq6[1]) + Q_W'(nsq6[2]);
      for (int i = 0; i < 3; i++) nmag7[i] <= nmag6[i];
      asum7 <= asum6;
      neg7  <= neg6;
      zero7 <= zero6;
      sat7  <= sat6;
    end
  end

  // square roots: lane 0 length, lane 1 albedo
  logic [1:0][Q_W-1:0]    sq_in;
  logic [1:0][ROOT_W-1:0] sq_root;
  sq_side_t               sq_side_in, sq_side_out;

  assign sq_in[0] = q7;
  assign sq_in[1] = Q_W'(asum7);

  always_comb begin
    sq_side_in.valid = v7;
    sq_side_in.zero  = zero7;
    sq_side_in.sat   = sat7;
    sq_side_in.neg   = neg7;
    for (int i = 0; i < 3; i++) sq_side_in.nmag[i] = nmag7[i];
  end

  pne_isqrt #(
    .W      (Q_W),
    .LANES  (2),
    .SIDE_W ($bits(sq_side_t))
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .value    (sq_in),
    .side_in  (sq_side_in),
    .root     (sq_root),
    .side_out (sq_side_out)
  );

  // division: round-half-up(mag * 2^14 / L)
  logic [2:0][NUM_W-1:0] dv_num;
  logic [2:0][QUO_W-1:0] dv_quo;
  div_side_t             dv_side_in, dv_side_out;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_num[i] = (NUM_W'(sq_side_out.nmag[i]) << UNIT_FRAC) +
                  NUM_W'(sq_root[0] >> 1);
    end
    dv_side_in.valid = sq_side_out.valid;
    dv_side_in.zero  = sq_side_out.zero;
    dv_side_in.sat   = sq_side_out.sat;
    dv_side_in.neg   = sq_side_out.neg;
    dv_side_in.alb   = sq_root[1];
  end

  pne_div #(
    .NW     (NUM_W),
    .DW     (ROOT_W),
    .QW     (QUO_W),
    .LANES  (3),
    .SIDE_W ($bits(div_side_t))
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .num      (dv_num),
    .den      (sq_root[0]),
    .side_in  (dv_side_in),
    .quo      (dv_quo),
    .side_out (dv_side_out)
  );

  // result assembly
  logic [2:0][UNIT_W-1:0] res_n;
  logic [ALB_W-1:0]       res_alb;
  logic                   res_deg;
  logic [QUO_W-1:0]       nq;
  logic                   push;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nq = (dv_quo[i] > UNIT_ONE) ? UNIT_ONE : dv_quo[i];
      if (dv_side_out.zero)        res_n[i] = '0;
      else if (dv_side_out.neg[i]) res_n[i] = UNIT_W'(0) - UNIT_W'(nq);
      else                         res_n[i] = UNIT_W'(nq);
    end
    if (dv_side_out.zero)                         res_alb = '0;
    else if (dv_side_out.sat)                     res_alb = ALBEDO_MAX;
    else if (dv_side_out.alb > ROOT_W'(ALBEDO_MAX)) res_alb = ALBEDO_MAX;
    else                                          res_alb = dv_side_out.alb[ALB_W-1:0];
    res_deg = dv_side_out.zero;
  end

  assign push = adv && dv_side_out.valid;

  // output register plus spare entry
  logic [2:0][UNIT_W-1:0] sp_n;
  logic [ALB_W-1:0]       sp_alb;
  logic                   sp_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      spare_v   <= 1'b0;
    end else if (spare_v) begin
      if (out_ready) begin
        out_valid <= 1'b1;
        spare_v   <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !out_ready) spare_v <= 1'b1;
      else                         out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (spare_v) begin
      if (out_ready) begin
        unit_nx    <= sp_n[0];
        unit_ny    <= sp_n[1];
        unit_nz    <= sp_n[2];
        albedo     <= sp_alb;
        degenerate <= sp_deg;
      end
    end else if (push) begin
      if (out_valid && !out_ready) begin
        sp_n   <= res_n;
        sp_alb <= res_alb;
        sp_deg <= res_deg;
      end else begin
        unit_nx    <= res_n[0];
        unit_ny    <= res_n[1];
        unit_nz    <= res_n[2];
        albedo     <= res_alb;
        degenerate <= res_deg;
      end
    end
  end

endmodule

FILE: sv/pne_isqrt.sv
`timescale 1ns / 1ps
module pne_isqrt #(
  parameter int W      = 54,
  parameter int LANES  = 2,
  parameter int SIDE_W = 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic [LANES-1:0][W-1:0]              value,
  input  logic [SIDE_W-1:0]                    side_in,
  output logic [LANES-1:0][(W+1)/2-1:0]        root,
  output logic [SIDE_W-1:0]                    side_out
);

  localparam int RW = (W + 1) / 2;
  localparam int TW = W + 2;

  logic [LANES-1:0][W-1:0]  rem_q  [1:RW];
  logic [LANES-1:0][RW-1:0] root_q [1:RW];
  logic [SIDE_W-1:0]        side_q [1:RW];

  for (genvar g = 0; g < RW; g++) begin : g_stage
    localparam int J = RW - 1 - g;
    logic [LANES-1:0][W-1:0]  cur_rem;
    logic [LANES-1:0][RW-1:0] cur_root;
    logic [SIDE_W-1:0]        cur_side;
    logic [LANES-1:0][TW-1:0] trial;
    logic [LANES-1:0]         ge;

    if (g == 0) begin : g_first
      assign cur_rem  = value;
      assign cur_root = '0;
      assign cur_side = side_in;
    end else begin : g_next
      assign cur_rem  = rem_q[g];
      assign cur_root = root_q[g];
      assign cur_side = side_q[g];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = (TW'(cur_root[l]) << (J + 1)) | (TW'(1) << (2 * J));
        ge[l]    = TW'(cur_rem[l]) >= trial[l];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        side_q[g+1] <= '0;
      end else if (en) begin
        side_q[g+1] <= cur_side;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          if (ge[l]) begin
            rem_q[g+1][l]  <= W'(TW'(cur_rem[l]) - trial[l]);
            root_q[g+1][l] <= cur_root[l] | (RW'(1) << J);
          end else begin
            rem_q[g+1][l]  <= cur_rem[l];
            root_q[g+1][l] <= cur_root[l];
          end
        end
      end
    end
  end

  assign root     = root_q[RW];
  assign side_out = side_q[RW];

endmodule

FILE: sv/pne_div.sv
`timescale 1ns / 1ps
module pne_div #(
  parameter int NW     = 41,
  parameter int DW     = 27,
  parameter int QW     = 15,
  parameter int LANES  = 3,
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [LANES-1:0][NW-1:0]      num,
  input  logic [DW-1:0]                 den,
  input  logic [SIDE_W-1:0]             side_in,
  output logic [LANES-1:0][QW-1:0]      quo,
  output logic [SIDE_W-1:0]             side_out
);

  localparam int TW = DW + QW;

  logic [LANES-1:0][NW-1:0] rem_q  [1:QW];
  logic [LANES-1:0][QW-1:0] quo_q  [1:QW];
  logic [DW-1:0]            den_q  [1:QW];
  logic [SIDE_W-1:0]        side_q [1:QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    localparam int J = QW - 1 - g;
    logic [LANES-1:0][NW-1:0] cur_rem;
    logic [LANES-1:0][QW-1:0] cur_quo;
    logic [DW-1:0]            cur_den;
    logic [SIDE_W-1:0]        cur_side;
    logic [TW-1:0]            trial;
    logic [LANES-1:0]         ge;

    if (g == 0) begin : g_first
      assign cur_rem  = num;
      assign cur_quo  = '0;
      assign cur_den  = den;
      assign cur_side = side_in;
    end else begin : g_next
      assign cur_rem  = rem_q[g];
      assign cur_quo  = quo_q[g];
      assign cur_den  = den_q[g];
      assign cur_side = side_q[g];
    end

    always_comb begin
      trial = TW'(cur_den) << J;
      for (int l = 0; l < LANES; l++) begin
        ge[l] = TW'(cur_rem[l]) >= trial;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        side_q[g+1] <= '0;
      end else if (en) begin
        side_q[g+1] <= cur_side;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[g+1] <= cur_den;
        for (int l = 0; l < LANES; l++) begin
          if (ge[l]) begin
            rem_q[g+1][l] <= NW'(TW'(cur_rem[l]) - trial);
            quo_q[g+1][l] <= cur_quo[l] | (QW'(1) << J);
          end else begin
            rem_q[g+1][l] <= cur_rem[l];
            quo_q[g+1][l] <= cur_quo[l];
          end
        end
      end
    end
  end

  assign quo      = quo_q[QW];
  assign side_out = side_q[QW];

endmodule
